FILE: design/mawin_pkg.sv
// shared constants and types for the median attention window block
package mawin_pkg;

    localparam int PROB_W   = 16;
    localparam int CDF_W    = 17;
    localparam int CNT_W    = 11;
    localparam int CFG_W    = 11;
    localparam int START_W  = 10;
    localparam int SPAN_W   = CFG_W + 1;
    localparam int CFG_IDX_W = 1;

    localparam logic [CNT_W-1:0] MAX_STEPS = CNT_W'(1024);
    localparam logic [CDF_W-1:0] HALF_Q16  = CDF_W'(32768);
    localparam logic [CDF_W-1:0] CDF_MAX   = {CDF_W{1'b1}};

    localparam logic [CFG_W-1:0] LEFT_WIDTH_RST  = CFG_W'(8);
    localparam logic [CFG_W-1:0] RIGHT_WIDTH_RST = CFG_W'(16);

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_LEFT_WIDTH  = t_cfg_idx'(0);
    localparam t_cfg_idx REG_RIGHT_WIDTH = t_cfg_idx'(1);

    // per-utterance totals handed from the accumulator to the window stage
    typedef struct packed {
        logic [CNT_W-1:0] len;
        logic [CNT_W-1:0] below;
    } t_utt_sum;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [CNT_W-1:0]   width;
        logic [CNT_W-1:0]   median;
    } t_window;

endpackage

FILE: design/mawin_accum.sv
// running sum, length and below-half counters for one utterance
module mawin_accum (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [mawin_pkg::PROB_W-1:0]  i_prob,
    input  logic                          i_last,
    output mawin_pkg::t_utt_sum           o_sum
);

    logic [mawin_pkg::CDF_W-1:0] r_cdf;
    logic [mawin_pkg::CNT_W-1:0] r_len;
    logic [mawin_pkg::CNT_W-1:0] r_below;
    logic [mawin_pkg::CDF_W-1:0] n_cdf;
    logic [mawin_pkg::CNT_W-1:0] n_len;
    logic [mawin_pkg::CNT_W-1:0] n_below;
    logic [mawin_pkg::CDF_W:0]   sum_wide;

    always_comb begin
        sum_wide = {1'b0, r_cdf} + {{(mawin_pkg::CDF_W + 1 - mawin_pkg::PROB_W){1'b0}}, i_prob};
        // saturate on carry out
        n_cdf = sum_wide[mawin_pkg::CDF_W] ? mawin_pkg::CDF_MAX
                                            : sum_wide[mawin_pkg::CDF_W-1:0];
        n_len   = r_len;
        n_below = r_below;
        if (r_len < mawin_pkg::MAX_STEPS) begin
            n_len = r_len + {{(mawin_pkg::CNT_W-1){1'b0}}, 1'b1};
            if (n_cdf < mawin_pkg::HALF_Q16) begin
                n_below = r_below + {{(mawin_pkg::CNT_W-1){1'b0}}, 1'b1};
            end
        end
    end

    assign o_sum.len   = n_len;
    assign o_sum.below = n_below;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cdf   <= '0;
            r_len   <= '0;
            r_below <= '0;
        end else if (i_accept) begin
            if (i_last) begin
                r_cdf   <= '0;
                r_len   <= '0;
                r_below <= '0;
            end else begin
                r_cdf   <= n_cdf;
                r_len   <= n_len;
                r_below <= n_below;
            end
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last) |=> (r_len == '0 && r_cdf == '0))
        else $error("utterance state not cleared after last request");

    a_below_le_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_below <= r_len)
        else $error("below-half count exceeds length");

    a_cdf_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_last) |=> r_cdf >= $past(r_cdf))
        else $error("running sum decreased within an utterance");

endmodule

FILE: design/mawin_window.sv
// window start and width from the utterance totals and the reach registers
module mawin_window (
    input  mawin_pkg::t_utt_sum           i_sum,
    input  logic                          i_first_step,
    input  logic [mawin_pkg::CFG_W-1:0]   i_left_width,
    input  logic [mawin_pkg::CFG_W-1:0]   i_right_width,
    output mawin_pkg::t_window            o_window
);

    logic [mawin_pkg::SPAN_W-1:0] span;
    logic                         covers;
    logic [mawin_pkg::CNT_W-1:0]  shifted;
    logic [mawin_pkg::CNT_W-1:0]  limit;
    logic [mawin_pkg::CNT_W-1:0]  start_full;

    always_comb begin
        span   = {1'b0, i_left_width} + {1'b0, i_right_width};
        covers = span >= {1'b0, i_sum.len};
        // median minus left reach, floored at zero
        shifted = (i_sum.below < i_left_width) ? '0 : (i_sum.below - i_left_width);
        // only used when span < len, so it fits the counter width
        limit = i_sum.len - span[mawin_pkg::CNT_W-1:0];
        if (i_first_step || covers) begin
            start_full = '0;
        end else if (shifted > limit) begin
            start_full = limit;
        end else begin
            start_full = shifted;
        end
        o_window.start  = start_full[mawin_pkg::START_W-1:0];
        o_window.width  = covers ? i_sum.len : span[mawin_pkg::CNT_W-1:0];
        o_window.median = i_sum.below;
    end

endmodule

FILE: design/median_attention_window_top.sv
// median attention window: top level with config, stage and output registers
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------------
//  input    | i_in_valid / o_in_stall   | i_prob, i_first_step, i_last
//  output   | o_out_valid / i_out_stall | o_window_start, o_window_width, o_median_index
//  config   | i_cfg_we                  | i_cfg_index, i_cfg_data
//
//  one request per cycle unless stalled; the running sum updates at the accepting edge
//  a last request's window passes through the stage register, then the output register
//  synchronous active-low reset clears counters, valids and sets reach registers to 8 / 16
//  output stall backs up the stage register and then stalls the input
module median_attention_window_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [mawin_pkg::PROB_W-1:0]  i_prob,
    input  logic                          i_first_step,
    input  logic                          i_last,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [mawin_pkg::START_W-1:0] o_window_start,
    output logic [mawin_pkg::CNT_W-1:0]   o_window_width,
    output logic [mawin_pkg::CNT_W-1:0]   o_median_index,
    input  logic                          i_cfg_we,
    input  mawin_pkg::t_cfg_idx           i_cfg_index,
    input  logic [mawin_pkg::CFG_W-1:0]   i_cfg_data
);

    logic [mawin_pkg::CFG_W-1:0] r_left_width;
    logic [mawin_pkg::CFG_W-1:0] r_right_width;
    logic                        r_s1_valid;
    mawin_pkg::t_utt_sum         r_s1_sum;
    logic                        r_s1_first;
    logic                        r_out_valid;
    mawin_pkg::t_window          r_out;

    mawin_pkg::t_utt_sum         acc_sum;
    mawin_pkg::t_window          win;
    logic                        in_accept;
    logic                        out_free;
    logic                        s1_free;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_free    = !r_s1_valid || out_free;
    assign o_in_stall = !s1_free;
    assign in_accept  = i_in_valid && s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_width  <= mawin_pkg::LEFT_WIDTH_RST;
            r_right_width <= mawin_pkg::RIGHT_WIDTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mawin_pkg::REG_LEFT_WIDTH: begin
                    r_left_width <= i_cfg_data;
                end
                mawin_pkg::REG_RIGHT_WIDTH: begin
                    r_right_width <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    mawin_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_prob   (i_prob),
        .i_last   (i_last),
        .o_sum    (acc_sum)
    );

    // stage register holds totals of a last request only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= in_accept && i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && i_last) begin
            r_s1_sum   <= acc_sum;
            r_s1_first <= i_first_step;
        end
    end

    mawin_window u_window (
        .i_sum         (r_s1_sum),
        .i_first_step  (r_s1_first),
        .i_left_width  (r_left_width),
        .i_right_width (r_right_width),
        .o_window      (win)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out <= win;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_window_start = r_out.start;
    assign o_window_width = r_out.width;
    assign o_median_index = r_out.median;

    a_width_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.width <= mawin_pkg::MAX_STEPS)
        else $error("window width beyond maximum length");

    a_median_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.median <= mawin_pkg::MAX_STEPS)
        else $error("median index beyond maximum length");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && i_out_stall) |=> (r_s1_valid && $stable(r_s1_sum)))
        else $error("stage register lost a pending window");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid))
        else $error("input stalled with room in the pipeline");

endmodule
